>>> rtl/dbf_pkg.sv
package dbf_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 14;
   localparam int NUM_BITS   = COORD_BITS + FRAC_BITS;
   localparam int DEN_BITS   = COORD_BITS - 1;
   localparam int STEP_BITS  = $clog2(NUM_BITS);
   localparam int VEL_BITS   = 16;
   localparam int IDX_BITS   = 3;
   localparam int DATA_BITS  = 16;

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic signed [VEL_BITS-1:0] vel_type;

   typedef enum logic [1:0] {
      CMD_PIXEL = 2'd0,
      CMD_ALT   = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   localparam logic [IDX_BITS-1:0] REG_THRESHOLD = 3'd0;
   localparam logic [IDX_BITS-1:0] REG_ROWS      = 3'd1;
   localparam logic [IDX_BITS-1:0] REG_COLS      = 3'd2;
   localparam logic [IDX_BITS-1:0] REG_HOVER     = 3'd3;
   localparam logic [IDX_BITS-1:0] REG_CLIMB     = 3'd4;
   localparam logic [IDX_BITS-1:0] REG_TIMEOUT   = 3'd5;
   localparam logic [IDX_BITS-1:0] REG_ENABLE    = 3'd6;

   typedef struct packed {
      logic [7:0]  threshold;
      coord_type   rows;
      coord_type   cols;
      logic [14:0] hover;
      logic [14:0] climb;
      logic [15:0] timeout;
      logic        enable;
   } cfg_type;

   // One finished frame handed from the front end to the back end
   typedef struct packed {
      logic               found;
      coord_type          row;
      coord_type          col;
      logic signed [15:0] alt;
      logic               hold;
   } job_type;

   typedef struct packed {
      vel_type   vel_x;
      vel_type   vel_y;
      vel_type   vel_z;
      logic      found;
      coord_type row;
      coord_type col;
   } result_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV_X,
      BK_DIV_Y,
      BK_WRITE
   } back_state_type;

   function automatic logic [DEN_BITS-1:0] centre(input coord_type size);
      logic [DEN_BITS-1:0] c;
      c = size[COORD_BITS-1:1];
      if (c == '0) c = DEN_BITS'(1);
      return c;
   endfunction

   function automatic logic signed [COORD_BITS:0] offset(input coord_type size,
                                                         input coord_type pos);
      return $signed({2'b00, centre(size)}) - $signed({1'b0, pos});
   endfunction

   function automatic logic [NUM_BITS-1:0] numerator(input logic signed [COORD_BITS:0] off);
      logic [COORD_BITS:0] mag;
      mag = off[COORD_BITS] ? -off : off;
      return {mag[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
   endfunction

   // Apply sign to the magnitude quotient and clamp to the velocity range
   function automatic vel_type sat_quot(input logic neg, input logic [NUM_BITS-1:0] q);
      vel_type v;
      if (!neg) begin
         if (q > NUM_BITS'(32767)) v = 16'sh7FFF;
         else                      v = q[VEL_BITS-1:0];
      end else begin
         if (q > NUM_BITS'(32768)) v = 16'sh8000;
         else                      v = -q[VEL_BITS-1:0];
      end
      return v;
   endfunction

endpackage

>>> rtl/dbf_div.sv
module dbf_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [dbf_pkg::NUM_BITS-1:0]      num,
   input  logic [dbf_pkg::DEN_BITS-1:0]      den,
   output logic                              done,
   output logic [dbf_pkg::NUM_BITS-1:0]      quot
);

   logic [dbf_pkg::NUM_BITS-1:0]  quot_ff, quot_in;
   logic [dbf_pkg::DEN_BITS-1:0]  rem_ff, rem_in;
   logic [dbf_pkg::DEN_BITS-1:0]  den_ff, den_in;
   logic [dbf_pkg::STEP_BITS-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [dbf_pkg::DEN_BITS:0]    rem_sh;
   logic [dbf_pkg::DEN_BITS:0]    rem_sub;
   logic                          fits;

   // One restoring step a cycle, numerator bits shift out as quotient bits shift in
   always_comb begin
      rem_sh  = {rem_ff, quot_ff[dbf_pkg::NUM_BITS-1]};
      fits    = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[dbf_pkg::NUM_BITS-2:0], fits};
         rem_in  = fits ? rem_sub[dbf_pkg::DEN_BITS-1:0] : rem_sh[dbf_pkg::DEN_BITS-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == dbf_pkg::STEP_BITS'(dbf_pkg::NUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> rtl/dbf_back.sv
module dbf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  dbf_pkg::cfg_type     cfg,
   input  logic                 job_valid,
   input  dbf_pkg::job_type     job,
   output logic                 job_pop,
   output logic                 res_valid,
   output dbf_pkg::result_type  res,
   input  logic                 res_pop
);

   dbf_pkg::back_state_type state_ff, state_in;
   dbf_pkg::job_type        job_ff, job_in;
   dbf_pkg::result_type     res_ff, res_in;
   dbf_pkg::vel_type        vx_ff, vx_in, vy_ff, vy_in, last_vz_ff, last_vz_in;
   logic                    res_valid_ff, res_valid_in;
   logic                    neg_ff, neg_in;
   logic [30:0]             prod_ff, prod_in;

   logic                          div_start, load_x, load_y, res_load;
   logic                          div_done;
   logic [dbf_pkg::NUM_BITS-1:0]  div_num, div_quot;
   logic [dbf_pkg::DEN_BITS-1:0]  div_den;
   logic signed [dbf_pkg::COORD_BITS:0] off;
   logic signed [16:0]            dh;
   logic signed [17:0]            dsearch;
   logic [22:0]                   prod_sh;
   dbf_pkg::vel_type              vz;

   dbf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dbf_pkg::BK_IDLE:
            if (job_valid) state_in = job.found ? dbf_pkg::BK_DIV_X : dbf_pkg::BK_WRITE;
         dbf_pkg::BK_DIV_X:
            if (div_done) state_in = dbf_pkg::BK_DIV_Y;
         dbf_pkg::BK_DIV_Y:
            if (div_done) state_in = dbf_pkg::BK_WRITE;
         dbf_pkg::BK_WRITE:
            if (!res_valid_ff || res_pop) state_in = dbf_pkg::BK_IDLE;
         default: state_in = dbf_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      job_pop   = 1'b0;
      div_start = 1'b0;
      load_x    = 1'b0;
      load_y    = 1'b0;
      res_load  = 1'b0;
      unique case (state_ff)
         dbf_pkg::BK_IDLE: begin
            job_pop   = job_valid;
            div_start = job_valid && job.found;
         end
         dbf_pkg::BK_DIV_X: begin
            load_x    = div_done;
            div_start = div_done;
         end
         dbf_pkg::BK_DIV_Y: load_y = div_done;
         dbf_pkg::BK_WRITE: res_load = !res_valid_ff || res_pop;
         default: ;
      endcase
   end

   // Rows go first from the queue head, columns follow from the held job
   always_comb begin
      if (state_ff == dbf_pkg::BK_IDLE) begin
         off     = dbf_pkg::offset(cfg.rows, job.row);
         div_den = dbf_pkg::centre(cfg.rows);
      end else begin
         off     = dbf_pkg::offset(cfg.cols, job_ff.col);
         div_den = dbf_pkg::centre(cfg.cols);
      end
      div_num = dbf_pkg::numerator(off);
   end

   always_comb begin
      dh      = $signed({job_ff.alt[15], job_ff.alt}) - $signed({2'b00, cfg.hover});
      dsearch = $signed({{2{job_ff.alt[15]}}, job_ff.alt})
              - $signed({2'b00, cfg.hover, 1'b0});
      prod_in = dh[15:0] * cfg.climb;
      prod_sh = prod_ff[30:8];
      if (job_ff.found) begin
         if (dh < -17'sd128)     vz = {1'b0, cfg.climb};
         else if (dh < 17'sd128) vz = '0;
         else if (prod_sh > 23'd32768) vz = 16'sh8000;
         else                    vz = -prod_sh[15:0];
      end else if (job_ff.hold) begin
         vz = last_vz_ff;
      end else if (dsearch < -18'sd256) begin
         vz = {1'b0, cfg.climb};
      end else if (dsearch > 18'sd256) begin
         vz = -{1'b0, cfg.climb};
      end else begin
         vz = '0;
      end
   end

   always_comb begin
      job_in       = job_pop ? job : job_ff;
      neg_in       = div_start ? off[dbf_pkg::COORD_BITS] : neg_ff;
      vx_in        = load_x ? dbf_pkg::sat_quot(neg_ff, div_quot) : vx_ff;
      vy_in        = load_y ? dbf_pkg::sat_quot(neg_ff, div_quot) : vy_ff;
      last_vz_in   = res_load ? vz : last_vz_ff;
      res_in       = res_ff;
      res_valid_in = res_valid_ff && !res_pop;
      if (res_load) begin
         res_in.vel_x = job_ff.found ? vx_ff : '0;
         res_in.vel_y = job_ff.found ? vy_ff : '0;
         res_in.vel_z = vz;
         res_in.found = job_ff.found;
         res_in.row   = job_ff.found ? job_ff.row : '0;
         res_in.col   = job_ff.found ? job_ff.col : '0;
         res_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dbf_pkg::BK_IDLE;
         res_valid_ff <= 1'b0;
         last_vz_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         res_valid_ff <= res_valid_in;
         last_vz_ff   <= last_vz_in;
      end
      job_ff  <= job_in;
      neg_ff  <= neg_in;
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

endmodule

>>> rtl/dbf_front.sv
module dbf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  dbf_pkg::cfg_type     cfg,
   input  logic                 push,
   output logic                 full,
   input  logic [1:0]           cmd,
   input  logic [7:0]           pixel_gray,
   input  logic                 end_of_frame,
   input  logic signed [15:0]   altitude,
   output logic                 job_valid,
   output dbf_pkg::job_type     job,
   input  logic                 job_pop
);

   dbf_pkg::coord_type row_ff, row_in, col_ff, col_in;
   dbf_pkg::coord_type hit_row_ff, hit_row_in, hit_col_ff, hit_col_in;
   logic               hit_seen_ff, hit_seen_in;
   logic signed [15:0] alt_ff, alt_in;
   logic [15:0]        ticks_ff, ticks_in;

   dbf_pkg::job_type   q_ff [2];
   dbf_pkg::job_type   job_w;
   logic               wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]         count_ff, count_in;

   logic               accept, job_push;
   dbf_pkg::coord_type nc, nr;

   assign full   = count_ff == 2'd2;
   assign accept = push && !full;

   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      hit_row_in  = hit_row_ff;
      hit_col_in  = hit_col_ff;
      hit_seen_in = hit_seen_ff;
      alt_in      = alt_ff;
      ticks_in    = ticks_ff;
      job_push    = 1'b0;
      job_w       = '0;
      nc          = col_ff + 1'b1;
      nr          = row_ff + 1'b1;
      if (accept) begin
         unique case (cmd)
            dbf_pkg::CMD_ALT: alt_in = altitude;
            dbf_pkg::CMD_TICK:
               if (ticks_ff != 16'hFFFF) ticks_in = ticks_ff + 1'b1;
            dbf_pkg::CMD_PIXEL:
               if (cfg.enable) begin
                  if (!hit_seen_ff && pixel_gray <= cfg.threshold) begin
                     hit_seen_in = 1'b1;
                     hit_row_in  = row_ff;
                     hit_col_in  = col_ff;
                  end
                  // Wrap the column at the frame width and the row at the frame height
                  if (nc == '0 || nc >= cfg.cols) begin
                     col_in = '0;
                     row_in = (nr >= cfg.rows) ? '0 : nr;
                  end else begin
                     col_in = nc;
                  end
                  if (end_of_frame) begin
                     job_push    = 1'b1;
                     job_w.found = hit_seen_in;
                     job_w.row   = hit_row_in;
                     job_w.col   = hit_col_in;
                     job_w.alt   = alt_ff;
                     job_w.hold  = ticks_ff < cfg.timeout;
                     row_in      = '0;
                     col_in      = '0;
                     hit_seen_in = 1'b0;
                     hit_row_in  = '0;
                     hit_col_in  = '0;
                     if (job_w.found) ticks_in = '0;
                  end
               end
            default: ;
         endcase
      end
   end

   always_comb begin
      wr_in    = job_push ? !wr_ff : wr_ff;
      rd_in    = job_pop ? !rd_ff : rd_ff;
      count_in = count_ff + {1'b0, job_push} - {1'b0, job_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         hit_seen_ff <= 1'b0;
         hit_row_ff  <= '0;
         hit_col_ff  <= '0;
         alt_ff      <= '0;
         ticks_ff    <= '0;
         wr_ff       <= 1'b0;
         rd_ff       <= 1'b0;
         count_ff    <= '0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         hit_seen_ff <= hit_seen_in;
         hit_row_ff  <= hit_row_in;
         hit_col_ff  <= hit_col_in;
         alt_ff      <= alt_in;
         ticks_ff    <= ticks_in;
         wr_ff       <= wr_in;
         rd_ff       <= rd_in;
         count_ff    <= count_in;
      end
      if (job_push) q_ff[wr_ff] <= job_w;
   end

   assign job_valid = count_ff != 2'd0;
   assign job       = q_ff[rd_ff];

endmodule

>>> rtl/dark_blob_follow_controller_unit.sv
// Camera-guided follow controller. Pixel, altitude and tick items are taken one per
// cycle by the front end while req_full is low; while enabled, it thresholds pixels,
// tracks the raster position and keeps the first dark pixel of the frame. The pixel
// flagged end_of_frame hands a frame record to a two-entry queue; the back end turns
// each record into one velocity item. A frame with a target runs two 26-step divisions
// (rows, then columns) through one shared bit-serial divider; a frame without a target
// goes from idle straight to the write state. req_full rises only while two frame
// records wait in the queue. Registers are to be written only while the block is idle.
module dark_blob_follow_controller_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [1:0]                        req_cmd,
   input  logic [7:0]                        req_pixel_gray,
   input  logic                              req_end_of_frame,
   input  logic signed [15:0]                req_altitude,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic signed [15:0]                rsp_vel_x,
   output logic signed [15:0]                rsp_vel_y,
   output logic signed [15:0]                rsp_vel_z,
   output logic                              rsp_target_found,
   output logic [dbf_pkg::COORD_BITS-1:0]    rsp_found_row,
   output logic [dbf_pkg::COORD_BITS-1:0]    rsp_found_col,
   input  logic                              csr_write,
   input  logic [dbf_pkg::IDX_BITS-1:0]      csr_index,
   input  logic [dbf_pkg::DATA_BITS-1:0]     csr_data
);

   dbf_pkg::cfg_type    cfg_ff, cfg_in;
   dbf_pkg::job_type    job;
   dbf_pkg::result_type res;
   logic                job_valid, job_pop, res_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            dbf_pkg::REG_THRESHOLD: cfg_in.threshold = csr_data[7:0];
            dbf_pkg::REG_ROWS:      cfg_in.rows      = csr_data[dbf_pkg::COORD_BITS-1:0];
            dbf_pkg::REG_COLS:      cfg_in.cols      = csr_data[dbf_pkg::COORD_BITS-1:0];
            dbf_pkg::REG_HOVER:     cfg_in.hover     = csr_data[14:0];
            dbf_pkg::REG_CLIMB:     cfg_in.climb     = csr_data[14:0];
            dbf_pkg::REG_TIMEOUT:   cfg_in.timeout   = csr_data;
            dbf_pkg::REG_ENABLE:    cfg_in.enable    = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= 8'd127;
         cfg_ff.rows      <= dbf_pkg::COORD_BITS'(480);
         cfg_ff.cols      <= dbf_pkg::COORD_BITS'(640);
         cfg_ff.hover     <= 15'd1024;
         cfg_ff.climb     <= 15'd1638;
         cfg_ff.timeout   <= 16'd5000;
         cfg_ff.enable    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dbf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .push         (req_push),
      .full         (req_full),
      .cmd          (req_cmd),
      .pixel_gray   (req_pixel_gray),
      .end_of_frame (req_end_of_frame),
      .altitude     (req_altitude),
      .job_valid    (job_valid),
      .job          (job),
      .job_pop      (job_pop)
   );

   dbf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop),
      .res_valid (res_valid),
      .res       (res),
      .res_pop   (rsp_pop)
   );

   assign rsp_empty        = !res_valid;
   assign rsp_vel_x        = res.vel_x;
   assign rsp_vel_y        = res.vel_y;
   assign rsp_vel_z        = res.vel_z;
   assign rsp_target_found = res.found;
   assign rsp_found_row    = res.row;
   assign rsp_found_col    = res.col;

endmodule
